FILE: rtl/core/mbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbp_pkg
// Shared types, constants and helpers of the MIDI byte stream parser.
// ----------------------------------------------------------------------------
package mbp_pkg;

    localparam int SYSEX_DEPTH = 64;
    localparam int SX_AW       = $clog2(SYSEX_DEPTH);
    localparam int SX_LW       = $clog2(SYSEX_DEPTH + 1);

    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] B_RT_MIN   = 8'hF8;
    localparam logic [7:0] B_CLOCK    = 8'hF8;
    localparam logic [7:0] B_START    = 8'hFA;
    localparam logic [7:0] B_CONTINUE = 8'hFB;
    localparam logic [7:0] B_STOP     = 8'hFC;
    localparam logic [7:0] B_SX_START = 8'hF0;
    localparam logic [7:0] B_SX_END   = 8'hF7;

    localparam logic [3:0] NIB_NOTE_OFF  = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON   = 4'h9;
    localparam logic [3:0] NIB_POLY_AT   = 4'hA;
    localparam logic [3:0] NIB_CTRL      = 4'hB;
    localparam logic [3:0] NIB_PROGRAM   = 4'hC;
    localparam logic [3:0] NIB_CHAN_AT   = 4'hD;
    localparam logic [3:0] NIB_PITCH     = 4'hE;

    localparam logic [1:0] DLEN_NONE = 2'd0;
    localparam logic [1:0] DLEN_ONE  = 2'd1;
    localparam logic [1:0] DLEN_TWO  = 2'd2;

    typedef enum logic [1:0] {
        EV_NOTE    = 2'd0,
        EV_RT      = 2'd1,
        EV_SYSEX   = 2'd2,
        EV_DISCARD = 2'd3
    } t_event_kind;

    typedef enum logic [1:0] {
        RT_CLOCK    = 2'd0,
        RT_START    = 2'd1,
        RT_CONTINUE = 2'd2,
        RT_STOP     = 2'd3
    } t_rt_code;

    typedef enum logic [2:0] {
        CMD_NOTE,
        CMD_RT,
        CMD_STORE,
        CMD_FLUSH,
        CMD_DISCARD
    } t_cmd_kind;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_SEND
    } t_back_state;

    typedef struct packed {
        t_cmd_kind        kind;
        logic [7:0]       data;
        logic [SX_AW-1:0] addr;
        logic             note_on;
        logic             del;
    } t_cmd;

    typedef struct packed {
        t_event_kind event_kind;
        logic [6:0]  note_number;
        logic        note_on;
        logic [1:0]  realtime_code;
        logic [7:0]  sysex_byte;
        logic        to_delegate;
        logic        last;
    } t_event;

    function automatic logic [1:0] data_len(input logic [3:0] nib);
        logic [1:0] len;
        case (nib) inside
            NIB_NOTE_OFF, NIB_NOTE_ON, NIB_POLY_AT, NIB_CTRL, NIB_PITCH: len = DLEN_TWO;
            NIB_PROGRAM, NIB_CHAN_AT: len = DLEN_ONE;
            default: len = DLEN_NONE;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/mbp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbp_if
// Valid/ready channels of the parser: received bytes, events, configuration.
// ----------------------------------------------------------------------------
interface mbp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] midi_byte;
    modport source (output valid, output midi_byte, input ready);
    modport sink   (input valid, input midi_byte, output ready);
endinterface

interface mbp_event_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_kind;
    logic [6:0] note_number;
    logic       note_on;
    logic [1:0] realtime_code;
    logic [7:0] sysex_byte;
    logic       to_delegate;
    logic       last;
    modport source (output valid, output event_kind, output note_number, output note_on,
                    output realtime_code, output sysex_byte, output to_delegate,
                    output last, input ready);
    modport sink   (input valid, input event_kind, input note_number, input note_on,
                    input realtime_code, input sysex_byte, input to_delegate,
                    input last, output ready);
endinterface

interface mbp_cfg_if;
    logic valid;
    logic ready;
    logic delegated_mode;
    modport source (output valid, output delegated_mode, input ready);
    modport sink   (input valid, input delegated_mode, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/mbp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbp_front
// Byte classifier: running status, sysex capture tracking, command issue.
// ----------------------------------------------------------------------------
module mbp_front import mbp_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mbp_byte_if.sink   i_byte,
    mbp_cfg_if.sink    i_cfg,
    input  wire logic  i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic             r_del;
    logic             r_in_sysex, n_in_sysex;
    logic [SX_LW-1:0] r_sx_len, n_sx_len;
    logic             r_rs_valid, n_rs_valid;
    logic [3:0]       r_rs_hi, n_rs_hi;
    logic             r_seen, n_seen;
    logic [6:0]       r_first, n_first;

    logic             accept;
    logic             do_clear;
    logic             rt_hit;
    logic [1:0]       rt_code;
    logic [SX_LW-1:0] len_eff;
    logic [7:0]       b;

    assign i_byte.ready = !i_full;
    assign i_cfg.ready  = 1'b1;
    assign accept       = i_byte.valid && !i_full;
    assign b            = i_byte.midi_byte;

    always_comb begin
        rt_hit = 1'b1;
        case (b)
            B_CLOCK:    rt_code = RT_CLOCK;
            B_START:    rt_code = RT_START;
            B_CONTINUE: rt_code = RT_CONTINUE;
            B_STOP:     rt_code = RT_STOP;
            default: begin
                rt_code = RT_CLOCK;
                rt_hit  = 1'b0;
            end
        endcase
    end

    assign len_eff = (b == B_SX_START) ? '0 : r_sx_len;

    always_comb begin
        n_in_sysex = r_in_sysex;
        n_sx_len   = r_sx_len;
        n_rs_valid = r_rs_valid;
        n_rs_hi    = r_rs_hi;
        n_seen     = r_seen;
        n_first    = r_first;
        do_clear   = 1'b0;
        o_push     = 1'b0;
        o_cmd      = '0;
        o_cmd.kind = CMD_STORE;
        o_cmd.del  = r_del;
        o_cmd.data = b;
        if (accept) begin
            if (b >= B_RT_MIN) begin
                o_cmd.kind = CMD_RT;
                o_cmd.data = {6'd0, rt_code};
                o_push     = rt_hit && !r_del;
            end else if (r_in_sysex) begin
                o_push = 1'b1;
                if (len_eff >= SX_LW'(SYSEX_DEPTH)) begin
                    o_cmd.kind = CMD_DISCARD;
                    o_cmd.data = '0;
                    do_clear   = 1'b1;
                end else begin
                    o_cmd.addr = len_eff[SX_AW-1:0];
                    if (b == B_SX_END) begin
                        o_cmd.kind = CMD_FLUSH;
                        do_clear   = 1'b1;
                    end else begin
                        n_sx_len = SX_LW'(len_eff + 1'b1);
                    end
                end
            end else if (b == B_SX_START) begin
                do_clear = 1'b1;
                o_push   = 1'b1;
            end else if (b[7]) begin
                n_seen = 1'b0;
                if (data_len(b[7:4]) != DLEN_NONE) begin
                    n_rs_valid = 1'b1;
                    n_rs_hi    = b[7:4];
                end else begin
                    n_rs_valid = 1'b0;
                    n_rs_hi    = '0;
                end
            end else if (r_rs_valid) begin
                if (!r_seen) begin
                    n_first = b[6:0];
                end
                if (data_len(r_rs_hi) == DLEN_TWO && !r_seen) begin
                    n_seen = 1'b1;
                end else begin
                    n_seen = 1'b0;
                    if (!r_del && (r_rs_hi == NIB_NOTE_OFF || r_rs_hi == NIB_NOTE_ON)) begin
                        o_push        = 1'b1;
                        o_cmd.kind    = CMD_NOTE;
                        o_cmd.data    = {1'b0, r_first};
                        o_cmd.note_on = (r_rs_hi == NIB_NOTE_ON) && (b[6:0] != 7'd0);
                    end
                end
            end
            if (do_clear) begin
                n_in_sysex = 1'b0;
                n_sx_len   = '0;
                n_rs_valid = 1'b0;
                n_rs_hi    = '0;
                n_seen     = 1'b0;
                n_first    = '0;
            end
            if (!r_in_sysex && b == B_SX_START) begin
                n_in_sysex = 1'b1;
                n_sx_len   = SX_LW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_del      <= 1'b0;
            r_in_sysex <= 1'b0;
            r_sx_len   <= '0;
            r_rs_valid <= 1'b0;
            r_rs_hi    <= '0;
            r_seen     <= 1'b0;
            r_first    <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_del <= i_cfg.delegated_mode;
            end
            r_in_sysex <= n_in_sysex;
            r_sx_len   <= n_sx_len;
            r_rs_valid <= n_rs_valid;
            r_rs_hi    <= n_rs_hi;
            r_seen     <= n_seen;
            r_first    <= n_first;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/mbp_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbp_cmd_fifo
// Short command queue between the classifier and the event sequencer.
// ----------------------------------------------------------------------------
module mbp_cmd_fifo import mbp_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_cmd  i_cmd,
    input  wire logic  i_pop,
    output t_cmd       o_cmd,
    output logic       o_full,
    output logic       o_empty
);

    t_cmd               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_CW-1:0] r_count, n_count;

    assign o_full  = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = FIFO_CW'(r_count + 1'b1);
        end else if (i_pop && !i_push) begin
            n_count = FIFO_CW'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= FIFO_AW'(r_wr_ptr + 1'b1);
            end
            if (i_pop) begin
                r_rd_ptr <= FIFO_AW'(r_rd_ptr + 1'b1);
            end
            r_count <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("command pushed into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("command popped from empty queue");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/mbp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbp_back
// Event sequencer: owns the sysex store, replays captured runs, drives events.
// ----------------------------------------------------------------------------
module mbp_back import mbp_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cmd  i_cmd,
    input  wire logic  i_empty,
    output logic       o_pop,
    mbp_event_if.source o_event
);

    logic [7:0]       r_mem [SYSEX_DEPTH];
    t_back_state      r_state, n_state;
    logic [SX_AW-1:0] r_rd_idx, n_rd_idx;
    logic [SX_AW-1:0] r_last_idx;
    logic             r_del;
    t_event           r_out;
    logic             mem_we;
    logic             send_done;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    case (i_cmd.kind)
                        CMD_NOTE, CMD_RT, CMD_DISCARD: n_state = BK_SEND;
                        CMD_FLUSH: n_state = BK_READ;
                        default: n_state = BK_IDLE;
                    endcase
                end
            end
            BK_READ: n_state = BK_SEND;
            BK_SEND: begin
                if (o_event.ready) begin
                    n_state = r_out.last ? BK_IDLE : BK_READ;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = (r_state == BK_IDLE) && !i_empty;
        mem_we    = o_pop && (i_cmd.kind == CMD_STORE || i_cmd.kind == CMD_FLUSH);
        send_done = (r_state == BK_SEND) && o_event.ready;
        n_rd_idx  = r_rd_idx;
        if (o_pop && i_cmd.kind == CMD_FLUSH) begin
            n_rd_idx = '0;
        end else if (send_done && !r_out.last) begin
            n_rd_idx = SX_AW'(r_rd_idx + 1'b1);
        end
        o_event.valid         = (r_state == BK_SEND);
        o_event.event_kind    = r_out.event_kind;
        o_event.note_number   = r_out.note_number;
        o_event.note_on       = r_out.note_on;
        o_event.realtime_code = r_out.realtime_code;
        o_event.sysex_byte    = r_out.sysex_byte;
        o_event.to_delegate   = r_out.to_delegate;
        o_event.last          = r_out.last;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_cmd.addr] <= i_cmd.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= '0;
            case (i_cmd.kind)
                CMD_NOTE: begin
                    r_out.event_kind  <= EV_NOTE;
                    r_out.note_number <= i_cmd.data[6:0];
                    r_out.note_on     <= i_cmd.note_on;
                    r_out.last        <= 1'b1;
                end
                CMD_RT: begin
                    r_out.event_kind    <= EV_RT;
                    r_out.realtime_code <= i_cmd.data[1:0];
                    r_out.last          <= 1'b1;
                end
                CMD_DISCARD: begin
                    r_out.event_kind  <= EV_DISCARD;
                    r_out.to_delegate <= i_cmd.del;
                    r_out.last        <= 1'b1;
                end
                default: begin
                end
            endcase
            r_last_idx <= i_cmd.addr;
            r_del      <= i_cmd.del;
        end else if (r_state == BK_READ) begin
            r_out             <= '0;
            r_out.event_kind  <= EV_SYSEX;
            r_out.sysex_byte  <= r_mem[r_rd_idx];
            r_out.to_delegate <= r_del;
            r_out.last        <= (r_rd_idx == r_last_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_rd_idx <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_idx <= n_rd_idx;
        end
    end

`ifndef SYNTHESIS
    a_read_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_READ) |-> (r_rd_idx <= r_last_idx))
        else $error("sysex replay index past end of run");
    a_read_then_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_READ) |=> (r_state == BK_SEND && r_out.event_kind == EV_SYSEX))
        else $error("sysex read not followed by sysex transfer");
    a_run_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (send_done && !r_out.last) |=>
            (r_state == BK_READ && r_rd_idx == SX_AW'($past(r_rd_idx) + 1'b1)))
        else $error("sysex replay did not advance by one");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/midi_byte_stream_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// midi_byte_stream_parser
// MIDI byte parser with running status, note and realtime events and sysex
// capture/replay, split into a classifier and an event sequencer.
//
//   channel   dir   payload                                   transfer
//   i_byte    in    midi_byte                                 valid & ready
//   i_cfg     in    delegated_mode                            valid & ready
//   o_event   out   event_kind, note_number, note_on,         valid & ready
//                   realtime_code, sysex_byte, to_delegate, last
//
// A byte is classified as it is accepted; a note, realtime or discard event
// is offered from the event register once popped from the command queue.
// Sysex replay: registered store read, then transfer, per byte, up to 64 bytes.
// i_byte stalls only while the four-entry command queue is full.
// i_cfg is always ready. Synchronous active-low reset clears parser state
// and the queue; the sysex store is not cleared.
// ----------------------------------------------------------------------------
module midi_byte_stream_parser import mbp_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mbp_byte_if.sink    i_byte,
    mbp_cfg_if.sink     i_cfg,
    mbp_event_if.source o_event
);

    logic push;
    logic pop;
    logic full;
    logic empty;
    t_cmd push_cmd;
    t_cmd head_cmd;

    mbp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_cfg   (i_cfg),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    mbp_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    mbp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (head_cmd),
        .i_empty (empty),
        .o_pop   (pop),
        .o_event (o_event)
    );

endmodule
`default_nettype wire
